// File: rtl/core/kcl_pkg.sv
// kcl_pkg: shared types, key codes, phases and constants for the keypad
// combination lock. No dependencies; used by every other file of the block but kcl_ifs.

package kcl_pkg;

	localparam int MaxCodeDigits = 6;

	typedef logic [3:0] key_t;
	typedef logic [2:0] pos_t;
	typedef logic [2:0] cnt3_t;

	localparam key_t KEY_ONE  = 4'd0;
	localparam key_t KEY_TWO  = 4'd1;
	localparam key_t KEY_FOUR = 4'd4;
	localparam key_t KEY_SIX  = 4'd6;
	localparam key_t KEY_STAR = 4'd12;
	localparam key_t KEY_ZERO = 4'd13;

	localparam pos_t  LEN_SHORT     = 3'd4;
	localparam pos_t  LEN_LONG      = 3'd6;
	localparam cnt3_t MAX_ATT_RESET = 3'd3;

	typedef enum logic [2:0] {
		PH_WELCOME = 3'd0,
		PH_PROMPT  = 3'd1,
		PH_MENU    = 3'd2,
		PH_ENTER   = 3'd3,
		PH_OLD     = 3'd4,
		PH_CHOOSE  = 3'd5,
		PH_NEW     = 3'd6
	} phase_t;

	// write request from the control logic to the code store
	typedef struct packed {
		logic we;
		pos_t pos;
		key_t key;
	} mem_wr_t;

	// one result item
	typedef struct packed {
		phase_t phase_now;
		logic   key_echoed;
		logic   access_granted;
		logic   code_rejected;
		logic   alarm_pulse;
		logic   code_updated;
		logic   red_lamp;
		cnt3_t  fails_used;
	} res_t;

endpackage

// File: rtl/core/kcl_ifs.sv
// kcl_ifs: valid/ready channel interfaces for key items, result items and
// the configuration write port. Depends on nothing.

interface kcl_key_if;
	logic       valid;
	logic       ready;
	logic [3:0] key_pos;

	modport source (output valid, output key_pos, input ready);
	modport sink (input valid, input key_pos, output ready);
endinterface

interface kcl_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] phase_now;
	logic       key_echoed;
	logic       access_granted;
	logic       code_rejected;
	logic       alarm_pulse;
	logic       code_updated;
	logic       red_lamp;
	logic [2:0] fails_used;

	modport source (output valid, output phase_now, output key_echoed,
		output access_granted, output code_rejected, output alarm_pulse,
		output code_updated, output red_lamp, output fails_used, input ready);
	modport sink (input valid, input phase_now, input key_echoed,
		input access_granted, input code_rejected, input alarm_pulse,
		input code_updated, input red_lamp, input fails_used, output ready);
endinterface

interface kcl_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] max_attempts;

	modport source (output valid, output max_attempts, input ready);
	modport sink (input valid, input max_attempts, output ready);
endinterface

// File: rtl/core/kcl_code_mem.sv
// kcl_code_mem: stored code digits in a small synchronous memory, read ahead
// at the next entry position. Depends on kcl_pkg.

module kcl_code_mem #(
	parameter int Depth = kcl_pkg::MaxCodeDigits
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kcl_pkg::mem_wr_t wr,
	input  kcl_pkg::pos_t    rd_pos,
	output kcl_pkg::key_t    rd_key
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	kcl_pkg::key_t    mem [0:Depth-1];
	logic [Depth-1:0] vld_q;
	kcl_pkg::key_t    rdata_q;
	logic             rvld_q;

	logic          wr_hit;
	logic          rd_hit;
	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;

	assign wr_idx = wr.pos[AW-1:0];
	assign rd_idx = rd_pos[AW-1:0];
	assign wr_hit = wr.we && ({1'b0, wr.pos} < 4'(Depth));
	assign rd_hit = {1'b0, rd_pos} < 4'(Depth);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_idx] <= wr.key;
		end
	end

	// forward a write to the entry that is read in the same cycle
	always_ff @(posedge clk) begin
		if (wr_hit && wr.pos == rd_pos) begin
			rdata_q <= wr.key;
		end else if (rd_hit) begin
			rdata_q <= mem[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_hit) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (wr_hit && wr.pos == rd_pos) begin
				rvld_q <= 1'b1;
			end else if (rd_hit) begin
				rvld_q <= vld_q[rd_idx];
			end else begin
				rvld_q <= 1'b0;
			end
		end
	end

	// entries never written hold the '0' key
	assign rd_key = rvld_q ? rdata_q : kcl_pkg::KEY_ZERO;

endmodule

// File: rtl/core/kcl_ctrl.sv
// kcl_ctrl: phase sequencer, entry position, failure count, lamp and the
// max_attempts register. Depends on kcl_pkg; pairs with kcl_code_mem.

module kcl_ctrl #(
	parameter int Depth = kcl_pkg::MaxCodeDigits
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  kcl_pkg::key_t    key,
	input  kcl_pkg::key_t    digit,
	input  logic             cfg_we,
	input  kcl_pkg::cnt3_t   cfg_max,
	output kcl_pkg::mem_wr_t wr,
	output kcl_pkg::pos_t    rd_pos,
	output kcl_pkg::res_t    res
);

	kcl_pkg::phase_t phase_q, phase_d;
	kcl_pkg::pos_t   pos_q, pos_d, len_q, len_d, pos_inc;
	kcl_pkg::cnt3_t  fail_q, fail_d, fail_inc, max_q;
	logic            mis_q, mis_d, mis_now;
	logic            red_q, red_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= kcl_pkg::PH_WELCOME;
			pos_q   <= '0;
			len_q   <= kcl_pkg::LEN_SHORT;
			fail_q  <= '0;
			mis_q   <= 1'b0;
			red_q   <= 1'b0;
			max_q   <= kcl_pkg::MAX_ATT_RESET;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			fail_q  <= fail_d;
			mis_q   <= mis_d;
			red_q   <= red_d;
			if (cfg_we) begin
				max_q <= cfg_max;
			end
		end
	end

	assign pos_inc  = pos_q + 3'd1;
	assign fail_inc = fail_q + 3'd1;
	// positions past the store never match
	assign mis_now  = mis_q || ({1'b0, pos_q} >= 4'(Depth)) || (digit != key);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		len_d   = len_q;
		fail_d  = fail_q;
		mis_d   = mis_q;
		red_d   = red_q;
		wr      = '0;
		res     = '0;
		if (accept) begin
			unique case (phase_q) inside
				kcl_pkg::PH_PROMPT: begin
					if (key == kcl_pkg::KEY_STAR) begin
						phase_d = kcl_pkg::PH_MENU;
					end
				end
				kcl_pkg::PH_MENU: begin
					if (key == kcl_pkg::KEY_ONE || key == kcl_pkg::KEY_TWO) begin
						phase_d = (key == kcl_pkg::KEY_ONE) ? kcl_pkg::PH_ENTER
							: kcl_pkg::PH_OLD;
						pos_d   = '0;
						mis_d   = 1'b0;
						fail_d  = '0;
					end
				end
				kcl_pkg::PH_ENTER, kcl_pkg::PH_OLD: begin
					res.key_echoed = 1'b1;
					mis_d = mis_now;
					pos_d = pos_inc;
					if (pos_inc >= len_q) begin
						pos_d = '0;
						mis_d = 1'b0;
						if (!mis_now) begin
							red_d = 1'b0;
							if (phase_q == kcl_pkg::PH_ENTER) begin
								res.access_granted = 1'b1;
								phase_d = kcl_pkg::PH_WELCOME;
							end else begin
								phase_d = kcl_pkg::PH_CHOOSE;
							end
						end else begin
							res.code_rejected = 1'b1;
							red_d  = 1'b1;
							fail_d = fail_inc;
							if (fail_inc >= max_q) begin
								res.alarm_pulse = 1'b1;
								red_d   = 1'b0;
								phase_d = kcl_pkg::PH_WELCOME;
							end
						end
					end
				end
				kcl_pkg::PH_CHOOSE: begin
					if (key == kcl_pkg::KEY_FOUR || key == kcl_pkg::KEY_SIX) begin
						len_d   = (key == kcl_pkg::KEY_FOUR) ? kcl_pkg::LEN_SHORT
							: kcl_pkg::LEN_LONG;
						pos_d   = '0;
						phase_d = kcl_pkg::PH_NEW;
					end
				end
				kcl_pkg::PH_NEW: begin
					res.key_echoed = 1'b1;
					wr.we  = 1'b1;
					wr.pos = pos_q;
					wr.key = key;
					pos_d  = pos_inc;
					if (pos_inc >= len_q) begin
						pos_d = '0;
						res.code_updated = 1'b1;
						phase_d = kcl_pkg::PH_WELCOME;
					end
				end
				default: begin
					phase_d = (key == kcl_pkg::KEY_STAR) ? kcl_pkg::PH_PROMPT
						: kcl_pkg::PH_WELCOME;
				end
			endcase
		end
		res.phase_now  = phase_d;
		res.red_lamp   = red_d;
		res.fails_used = fail_d;
	end

	// the store prefetches the digit for the next item
	assign rd_pos = pos_d;

endmodule

// File: rtl/core/kcl_out_buf.sv
// kcl_out_buf: two-entry result queue that drives the result channel, so
// new items keep coming while a result waits. Depends on kcl_pkg, kcl_ifs.

module kcl_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kcl_pkg::res_t din,
	output logic          space,
	kcl_res_if.source     results
);

	kcl_pkg::res_t slot_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          pop;
	kcl_pkg::res_t head;

	assign space = (cnt_q != 2'd2);
	assign pop   = results.valid && results.ready;
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign results.valid          = (cnt_q != 2'd0);
	assign results.phase_now      = head.phase_now;
	assign results.key_echoed     = head.key_echoed;
	assign results.access_granted = head.access_granted;
	assign results.code_rejected  = head.code_rejected;
	assign results.alarm_pulse    = head.alarm_pulse;
	assign results.code_updated   = head.code_updated;
	assign results.red_lamp       = head.red_lamp;
	assign results.fails_used     = head.fails_used;

endmodule

// File: rtl/core/keypad_combination_lock_unit.sv
// keypad_combination_lock_unit: one key item in, one result item out.
// The result is registered in the output queue when the key is taken and shows on the result channel from there.
// Throughput: one key per cycle while the output queue has space; the code store is read ahead at the next position.
// keys.ready drops only while two results wait in the output queue.
// Reset: welcome phase, 4-digit code of '0' keys (per-entry valid bits), max_attempts 3.
// Depends on kcl_pkg, kcl_ifs, kcl_code_mem, kcl_ctrl, kcl_out_buf.

module keypad_combination_lock_unit #(
	parameter int MAX_CODE_DIGITS = kcl_pkg::MaxCodeDigits
) (
	input  logic      clk,
	input  logic      arst_n,
	kcl_key_if.sink   keys,
	kcl_res_if.source results,
	kcl_cfg_if.sink   cfg
);

	logic             accept;
	logic             space;
	kcl_pkg::mem_wr_t wr;
	kcl_pkg::pos_t    rd_pos;
	kcl_pkg::key_t    digit;
	kcl_pkg::res_t    res;

	assign keys.ready = space;
	assign cfg.ready  = 1'b1;
	assign accept     = keys.valid && space;

	kcl_code_mem #(.Depth(MAX_CODE_DIGITS)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_pos (rd_pos),
		.rd_key (digit)
	);

	kcl_ctrl #(.Depth(MAX_CODE_DIGITS)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.key     (keys.key_pos),
		.digit   (digit),
		.cfg_we  (cfg.valid),
		.cfg_max (cfg.max_attempts),
		.wr      (wr),
		.rd_pos  (rd_pos),
		.res     (res)
	);

	kcl_out_buf u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.din     (res),
		.space   (space),
		.results (results)
	);

	// a stalled key side means results are waiting
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!keys.ready |-> results.valid)
		else $error("key side stalled with no result waiting");

	a_outcome_excl: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> $onehot0({results.access_granted, results.code_rejected,
			results.code_updated}))
		else $error("more than one outcome in one result item");

	a_end_to_welcome: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.access_granted || results.alarm_pulse
			|| results.code_updated) |-> results.phase_now == kcl_pkg::PH_WELCOME)
		else $error("finished flow did not return to welcome");

	a_outcome_needs_digit: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.key_echoed |-> !results.access_granted
			&& !results.code_rejected && !results.code_updated)
		else $error("outcome on a key not taken as a digit");

	a_alarm_lamp_off: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.alarm_pulse |-> results.code_rejected
			&& !results.red_lamp)
		else $error("alarm without rejection or with lamp lit");

endmodule

// File: tb/kcl_lock_checker.sv
`timescale 1ns / 1ps
// kcl_lock_checker: watches the key, result and config channels of the keypad lock,
// predicts every result item and compares it field by field.
// Depends on kcl_pkg and kcl_ifs.

module kcl_lock_checker import kcl_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	kcl_key_if                              keys,
	kcl_res_if                              results,
	kcl_cfg_if                              cfg,
	output int                              errors,
	output int                              pending,
	output int                              n_grant,
	output int                              n_reject,
	output int                              n_alarm,
	output int                              n_update,
	output phase_t                          lock_phase,
	output pos_t                            lock_pos,
	output pos_t                            lock_len,
	output logic [MaxCodeDigits-1:0][3:0]   lock_code
);

	logic  miss;
	cnt3_t fails;
	logic  red;
	cnt3_t max_att;
	res_t  expected_q[$];

	// start of an open or change flow
	function automatic void open_flow(input phase_t p);
		lock_phase = p;
		lock_pos = '0;
		miss = 1'b0;
		fails = '0;
	endfunction

	function automatic res_t advance_lock(input key_t k);
		res_t r;
		r = '0;
		case (lock_phase)
			PH_PROMPT: begin
				if (k == KEY_STAR) lock_phase = PH_MENU;
			end
			PH_MENU: begin
				if (k == KEY_ONE) open_flow(PH_ENTER);
				else if (k == KEY_TWO) open_flow(PH_OLD);
			end
			PH_ENTER, PH_OLD: begin
				r.key_echoed = 1'b1;
				if (lock_pos >= MaxCodeDigits || lock_code[lock_pos] != k) miss = 1'b1;
				lock_pos = lock_pos + 3'd1;
				if (lock_pos >= lock_len) begin
					lock_pos = '0;
					if (!miss) begin
						red = 1'b0;
						if (lock_phase == PH_ENTER) begin
							r.access_granted = 1'b1;
							lock_phase = PH_WELCOME;
						end else begin
							lock_phase = PH_CHOOSE;
						end
					end else begin
						r.code_rejected = 1'b1;
						red = 1'b1;
						fails = fails + 3'd1;
						if (fails >= max_att) begin
							r.alarm_pulse = 1'b1;
							red = 1'b0;
							lock_phase = PH_WELCOME;
						end
					end
					miss = 1'b0;
				end
			end
			PH_CHOOSE: begin
				if (k == KEY_FOUR || k == KEY_SIX) begin
					lock_len = (k == KEY_FOUR) ? LEN_SHORT : LEN_LONG;
					lock_pos = '0;
					lock_phase = PH_NEW;
				end
			end
			PH_NEW: begin
				r.key_echoed = 1'b1;
				if (lock_pos < MaxCodeDigits) lock_code[lock_pos] = k;
				lock_pos = lock_pos + 3'd1;
				if (lock_pos >= lock_len) begin
					lock_pos = '0;
					r.code_updated = 1'b1;
					lock_phase = PH_WELCOME;
				end
			end
			default: begin
				lock_phase = (k == KEY_STAR) ? PH_PROMPT : PH_WELCOME;
			end
		endcase
		r.phase_now = lock_phase;
		r.red_lamp = red;
		r.fails_used = fails;
		return r;
	endfunction

	function automatic int field_diff(input string fname, input logic [3:0] exp_v,
			input logic [3:0] got_v);
		if (exp_v === got_v) return 0;
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, exp_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t seen;
		if (!arst_n) begin
			max_att = MAX_ATT_RESET;
			lock_phase = PH_WELCOME;
			lock_len = LEN_SHORT;
			for (int i = 0; i < MaxCodeDigits; i++) lock_code[i] = KEY_ZERO;
			lock_pos = '0;
			miss = 1'b0;
			fails = '0;
			red = 1'b0;
			expected_q.delete();
			errors = 0;
			pending = 0;
			n_grant = 0;
			n_reject = 0;
			n_alarm = 0;
			n_update = 0;
		end else begin
			// pop before push: a result always belongs to an older item
			if (results.valid && results.ready) begin
				seen.phase_now = phase_t'(results.phase_now);
				seen.key_echoed = results.key_echoed;
				seen.access_granted = results.access_granted;
				seen.code_rejected = results.code_rejected;
				seen.alarm_pulse = results.alarm_pulse;
				seen.code_updated = results.code_updated;
				seen.red_lamp = results.red_lamp;
				seen.fails_used = results.fails_used;
				if (expected_q.size() == 0) begin
					$display("%0t: result with no item waiting: expected none, got %h",
						$time, seen);
					errors++;
				end else begin
					want = expected_q.pop_front();
					errors += field_diff("phase_now", want.phase_now, seen.phase_now);
					errors += field_diff("key_echoed", want.key_echoed, seen.key_echoed);
					errors += field_diff("access_granted", want.access_granted,
						seen.access_granted);
					errors += field_diff("code_rejected", want.code_rejected,
						seen.code_rejected);
					errors += field_diff("alarm_pulse", want.alarm_pulse, seen.alarm_pulse);
					errors += field_diff("code_updated", want.code_updated,
						seen.code_updated);
					errors += field_diff("red_lamp", want.red_lamp, seen.red_lamp);
					errors += field_diff("fails_used", want.fails_used, seen.fails_used);
				end
			end
			if (cfg.valid && cfg.ready) max_att = cfg.max_attempts;
			if (keys.valid && keys.ready) begin
				want = advance_lock(keys.key_pos);
				n_grant += want.access_granted;
				n_reject += want.code_rejected;
				n_alarm += want.alarm_pulse;
				n_update += want.code_updated;
				expected_q.push_back(want);
			end
			pending = expected_q.size();
		end
	end

endmodule

// File: tb/keypad_combination_lock_unit_test.sv
`timescale 1ns / 1ps
// keypad_combination_lock_unit_test: clock, reset, key and config stimulus, result
// back-pressure and verdict; prediction lives in kcl_lock_checker.
// Depends on kcl_pkg, kcl_ifs, keypad_combination_lock_unit and kcl_lock_checker.

module keypad_combination_lock_unit_test import kcl_pkg::*; ();

	localparam int StallLimit = 2000;
	localparam int ItemsPerSetting = 316;
	localparam int HoldCycles = 60;

	logic clk;
	logic arst_n;

	kcl_key_if keys_if();
	kcl_res_if res_if();
	kcl_cfg_if cfg_if();

	int     errors, pending, n_grant, n_reject, n_alarm, n_update;
	phase_t lock_phase;
	pos_t   lock_pos, lock_len;
	logic [MaxCodeDigits-1:0][3:0] lock_code;

	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_reqs;
	int   bad_pct;
	pos_t bad_slot;
	int   n_items;

	keypad_combination_lock_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.keys    (keys_if),
		.results (res_if),
		.cfg     (cfg_if)
	);

	kcl_lock_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.keys       (keys_if),
		.results    (res_if),
		.cfg        (cfg_if),
		.errors     (errors),
		.pending    (pending),
		.n_grant    (n_grant),
		.n_reject   (n_reject),
		.n_alarm    (n_alarm),
		.n_update   (n_update),
		.lock_phase (lock_phase),
		.lock_pos   (lock_pos),
		.lock_len   (lock_len),
		.lock_code  (lock_code)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random stalls plus an occasional long hold-off
	initial begin
		int holds_done;
		holds_done = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				res_if.ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((keys_if.valid && keys_if.ready) || (res_if.valid && res_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("keypad_combination_lock_unit regression: fail");
		$finish;
	end

	// true when the key moves the lock rather than being ignored
	function automatic bit key_acts(input phase_t p, input key_t k);
		case (p)
			PH_ENTER, PH_OLD, PH_NEW: return 1'b1;
			PH_MENU: return k == KEY_ONE || k == KEY_TWO;
			PH_CHOOSE: return k == KEY_FOUR || k == KEY_SIX;
			default: return k == KEY_STAR;
		endcase
	endfunction

	// mostly well-formed flows, sometimes a wrong digit, some pure noise
	function automatic key_t pick_key();
		key_t k;
		k = key_t'($urandom_range(15));
		if ($urandom_range(99) < 8) return k;
		case (lock_phase)
			PH_WELCOME, PH_PROMPT: k = KEY_STAR;
			PH_MENU: k = $urandom_range(1) ? KEY_ONE : KEY_TWO;
			PH_CHOOSE: k = $urandom_range(1) ? KEY_FOUR : KEY_SIX;
			PH_ENTER, PH_OLD: begin
				if (lock_pos == 0)
					bad_slot = ($urandom_range(99) < bad_pct) ?
						pos_t'($urandom_range(lock_len - 1)) : 3'd7;
				k = lock_code[lock_pos];
				if (lock_pos == bad_slot) k = k ^ key_t'($urandom_range(1, 15));
			end
			default: ;
		endcase
		return k;
	endfunction

	task automatic send_key(input key_t k);
		while ($urandom_range(99) < send_idle_pct) begin
			keys_if.valid <= 1'b0;
			@(negedge clk);
		end
		keys_if.valid <= 1'b1;
		keys_if.key_pos <= k;
		if (key_acts(lock_phase, k)) n_items++;
		@(posedge clk);
		while (!keys_if.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_max_attempts(input cnt3_t v);
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.max_attempts <= v;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		key_t  script[$];
		cnt3_t settings[6];
		int    sent;
		script = '{4'd5, KEY_STAR, 4'd3, KEY_STAR, 4'd7, KEY_ONE,
			KEY_ZERO, KEY_ZERO, KEY_ZERO, KEY_STAR,
			KEY_ZERO, KEY_ZERO, KEY_ZERO, KEY_ZERO,
			KEY_STAR, KEY_STAR, KEY_TWO, KEY_ZERO, KEY_ZERO, KEY_ZERO, KEY_ZERO,
			4'd9, KEY_SIX, 4'd15, KEY_STAR, KEY_ONE, 4'd14, 4'd3, 4'd5};
		settings = '{3'd1, 3'd7, 3'd0, 3'd4, 3'd2, 3'd6};
		arst_n = 1'b0;
		keys_if.valid = 1'b0;
		keys_if.key_pos = '0;
		cfg_if.valid = 1'b0;
		cfg_if.max_attempts = '0;
		send_idle_pct = 37;
		recv_idle_pct = 59;
		hold_reqs = 0;
		bad_pct = 30;
		bad_slot = 3'd7;
		n_items = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset code and attempts: ignored keys, a reject, a grant, a change to six digits
		foreach (script[i]) send_key(script[i]);

		foreach (settings[p]) begin
			keys_if.valid <= 1'b0;
			write_max_attempts(settings[p]);
			case (p / 2)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (p == 4) hold_reqs++;
			bad_pct = $urandom_range(15, 60);
			sent = n_items;
			while (n_items - sent < ItemsPerSetting) send_key(pick_key());
		end
		keys_if.valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d active key items over max_attempts 3,1,7,0,4,2,6 with idling",
			n_items);
		$display("  and a long result hold: %0d grants, %0d rejects, %0d alarms, %0d changes",
			n_grant, n_reject, n_alarm, n_update);
		if (errors == 0 && pending == 0)
			$display("keypad_combination_lock_unit regression: pass");
		else
			$display("keypad_combination_lock_unit regression: fail");
		$finish;
	end

endmodule
